>>> sv/sorted_sleep_wakeup_queue_defines.svh
// assertion macros for the sorted sleep wake-up queue
`ifndef SORTED_SLEEP_WAKEUP_QUEUE_DEFINES_SVH
`define SORTED_SLEEP_WAKEUP_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while in reset
`define SSWQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sswq assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SSWQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sswq assertion failed");

`else

`define SSWQ_ASSERT_IMP(lbl, ante, cons)
`define SSWQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/sswq_pkg.sv
// shared types, constants and helpers of the sorted sleep wake-up queue
package sswq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 8;
    localparam int MAX_RESULTS = 32;
    localparam int TICK_W      = 63;
    localparam int TASK_W      = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [NRES_W-1:0]  nres_t;
    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [TICK_W-1:0]  tick_t;

    // operation codes of a request
    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_IDLE     = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_WOKEN    = 3'd3,
        STAT_NONE     = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHECK,
        S_INS_CMP,
        S_TICK_READ,
        S_TICK_CMP
    } state_t;

    // write port of the entry store
    typedef struct packed {
        logic  en;
        ptr_t  addr;
        id_t   id;
        tick_t tick;
    } mem_wr_t;

    // read port of the entry store
    typedef struct packed {
        logic en;
        ptr_t addr;
    } mem_rd_t;

    // circular buffer address: base plus offset, wrapped at the queue depth
    function automatic ptr_t wrap_add(ptr_t base, ptr_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> sv/sswq_req_if.sv
// request channel of the sorted sleep wake-up queue
interface sswq_req_if;
    import sswq_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [TASK_W-1:0]   task_id;
    logic [TICK_W-1:0]   wake_tick;
    logic [TICK_W-1:0]   now_tick;

    modport source (output valid, output operation, output task_id,
                    output wake_tick, output now_tick, input ready);
    modport sink   (input valid, input operation, input task_id,
                    input wake_tick, input now_tick, output ready);
endinterface

>>> sv/sswq_rsp_if.sv
// response channel of the sorted sleep wake-up queue
interface sswq_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] woken_id;
    logic       last;

    modport source (output valid, output status, output woken_id, output last,
                    input ready);
    modport sink   (input valid, input status, input woken_id, input last,
                    output ready);
endinterface

>>> sv/sswq_store.sv
// entry store: id and wake tick per slot, one write and one registered read
module sswq_store (
    input  logic              clk,
    input  sswq_pkg::mem_wr_t wr,
    input  sswq_pkg::mem_rd_t rd,
    output sswq_pkg::id_t     rd_id,
    output sswq_pkg::tick_t   rd_tick
);
    import sswq_pkg::*;

    id_t   id_mem   [QUEUE_DEPTH];
    tick_t tick_mem [QUEUE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            id_mem[wr.addr]   <= wr.id;
            tick_mem[wr.addr] <= wr.tick;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_id   <= id_mem[rd.addr];
            rd_tick <= tick_mem[rd.addr];
        end
    end

endmodule

>>> sv/sorted_sleep_wakeup_queue.sv
// sorted sleep wake-up queue: circular entry store walked by a one-comparator sequencer
// sleep: an idle-id or full request answers straight from idle; an insert walks back from the tail,
// moving each later entry up one slot, and stops at an earlier due entry or at the head
// tick: each entry checked is read, then goes through the shared 63-bit compare, then the answer is loaded;
// each woken result holds the next read until the one-deep output register is taken
// reset clears state, count, head pointer, idle id and output valid; the store is not cleared
`include "sorted_sleep_wakeup_queue_defines.svh"

module sorted_sleep_wakeup_queue (
    input  logic        clk,
    input  logic        rst_n,
    sswq_req_if.sink    req,
    sswq_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import sswq_pkg::*;

    state_t  state_reg, state_next;
    ptr_t    head_reg, head_next;
    cnt_t    count_reg, count_next;
    cnt_t    idx_reg, idx_next;
    nres_t   nres_reg, nres_next;
    tick_t   key_reg, key_next;
    id_t     id_reg, id_next;
    id_t     pend_id_reg, pend_id_next;
    logic    have_pend_reg, have_pend_next;
    logic [7:0] idle_id_reg, idle_id_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    logic [7:0] out_id_reg, out_id_next;
    logic    out_last_reg, out_last_next;

    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    id_t     rd_id;
    tick_t   rd_tick;

    logic    accept;
    logic    due;
    logic    emit;
    status_t emit_status;
    logic [7:0] emit_id;
    logic    emit_last;

    sswq_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_id   (rd_id),
        .rd_tick (rd_tick)
    );

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = req.valid && req.ready;

    // the shared comparator: stored tick against the request key
    assign due = (rd_tick <= key_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idle_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            nres_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idle_id_reg   <= idle_id_next;
            out_valid_reg <= out_valid_next;
            have_pend_reg <= have_pend_next;
            nres_reg      <= nres_next;
            idx_reg       <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        id_reg         <= id_next;
        pend_id_reg    <= pend_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    // sequencer: next state, store access and result loading
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        nres_next      = nres_reg;
        key_next       = key_reg;
        id_next        = id_reg;
        pend_id_next   = pend_id_reg;
        have_pend_next = have_pend_reg;
        idle_id_next   = cfg_we ? cfg_wdata : idle_id_reg;

        mem_wr      = '0;
        mem_rd      = '0;
        emit        = 1'b0;
        emit_status = STAT_NONE;
        emit_id     = '0;
        emit_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(req.operation) == OP_TICK)
                    begin
                        key_next       = req.now_tick;
                        nres_next      = '0;
                        have_pend_next = 1'b0;
                        state_next     = S_TICK_READ;
                    end
                    else if (req.task_id[ID_BITS-1:0] == idle_id_reg[ID_BITS-1:0])
                    begin
                        emit        = 1'b1;
                        emit_status = STAT_IDLE;
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        emit        = 1'b1;
                        emit_status = STAT_FULL;
                    end
                    else
                    begin
                        key_next   = req.wake_tick;
                        id_next    = req.task_id[ID_BITS-1:0];
                        idx_next   = count_reg;
                        state_next = S_INS_CHECK;
                    end
                end
            end

            // walk back from the tail: place new entry or fetch the one before
            S_INS_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = head_reg;
                    mem_wr.id   = id_reg;
                    mem_wr.tick = key_reg;
                    count_next  = count_reg + CNT_W'(1);
                    emit        = 1'b1;
                    emit_status = STAT_INSERTED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = wrap_add(head_reg, PTR_W'(idx_reg - CNT_W'(1)));
                    state_next  = S_INS_CMP;
                end
            end

            // equal ticks stay ahead of the new entry
            S_INS_CMP:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = wrap_add(head_reg, PTR_W'(idx_reg));
                if (due)
                begin
                    mem_wr.id   = id_reg;
                    mem_wr.tick = key_reg;
                    count_next  = count_reg + CNT_W'(1);
                    emit        = 1'b1;
                    emit_status = STAT_INSERTED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_wr.id   = rd_id;
                    mem_wr.tick = rd_tick;
                    idx_next    = idx_reg - CNT_W'(1);
                    state_next  = S_INS_CHECK;
                end
            end

            // wait for a free result slot, then fetch the front entry or finish
            S_TICK_READ:
            begin
                if (!out_valid_reg)
                begin
                    if ((count_reg == '0) || (nres_reg == NRES_W'(MAX_RESULTS)))
                    begin
                        emit        = 1'b1;
                        emit_status = have_pend_reg ? STAT_WOKEN : STAT_NONE;
                        emit_id     = have_pend_reg ? 8'(pend_id_reg) : 8'd0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = head_reg;
                        state_next  = S_TICK_CMP;
                    end
                end
            end

            // pop a due entry; the held one goes out once a successor is known
            S_TICK_CMP:
            begin
                if (due)
                begin
                    pend_id_next   = rd_id;
                    have_pend_next = 1'b1;
                    head_next      = wrap_add(head_reg, PTR_W'(1));
                    count_next     = count_reg - CNT_W'(1);
                    nres_next      = nres_reg + NRES_W'(1);
                    emit           = have_pend_reg;
                    emit_status    = STAT_WOKEN;
                    emit_id        = 8'(pend_id_reg);
                    emit_last      = 1'b0;
                    state_next     = S_TICK_READ;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = have_pend_reg ? STAT_WOKEN : STAT_NONE;
                    emit_id     = have_pend_reg ? 8'(pend_id_reg) : 8'd0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_id_next     = emit_id;
            out_last_next   = emit_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.woken_id = out_id_reg;
    assign rsp.last     = out_last_reg;

    // checks on the sequencer
    `SSWQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SSWQ_ASSERT_IMP(a_slot_free_cmp, state_reg == S_TICK_CMP, !out_valid_reg)
    `SSWQ_ASSERT_NEXT(a_read_before_cmp, mem_rd.en,
        (state_reg == S_TICK_CMP) || (state_reg == S_INS_CMP))
    `SSWQ_ASSERT_IMP(a_no_emit_over_full, emit, !out_valid_reg)

endmodule
